/* rtl/q2e_pkg.sv */
`default_nettype none
package q2e_pkg;

	localparam int QW = 16;                  // Q2.14 input component width
	localparam int PW = 2 * QW;              // product width
	localparam int SW = 35;                  // width of the Q.28 sums
	localparam int CW = 38;                  // vectoring datapath width
	localparam int AW = 32;                  // internal angle, 2^32 per turn
	localparam int OW = 16;                  // output binary angle width
	localparam int STEPS = 30;               // vectoring iterations
	localparam int NW = 57;                  // radicand width, up to 2^56
	localparam int RW = 30;                  // root register width
	localparam int ROOT_STEPS = 29;          // one result bit per step
	localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< 28);
	localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [AW-1:0] ROUND_HALF = 32'h0000_8000;

	typedef logic signed [SW-1:0] sum_t;
	typedef logic signed [CW-1:0] vec_t;
	typedef logic [AW-1:0] ang_t;

	// Arctangent of 2^-i in 2^32 units per turn.
	function automatic ang_t atan_turn(input int i);
		ang_t t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
			15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
			21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
			24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

/* rtl/q2e_isqrt.sv */
`default_nettype none
module q2e_isqrt
	import q2e_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NW-1:0]     sq,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [RW-2:0]          root,
	output logic [SIDE_W-1:0]      side_out
);

	logic              v_s [0:ROOT_STEPS];
	logic [NW-1:0]     n_s [0:ROOT_STEPS];
	logic [NW-1:0]     r_s [0:ROOT_STEPS];
	logic [SIDE_W-1:0] d_s [0:ROOT_STEPS];

	localparam logic [NW-1:0] RAD_TOP = NW'(1) << (NW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= RAD_TOP - sq;
			r_s[0] <= '0;
			d_s[0] <= side_in;
		end
	end

	// Digit-by-digit root: stage j tests the bit of weight 4^(28-j).
	// The partial root is kept scaled by the current bit weight, so the
	// early stages need the full radicand width.
	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (ROOT_STEPS - 1 - j));
		logic [NW-1:0] trial;
		logic          fits;

		assign trial = r_s[j] + BIT;
		assign fits  = n_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j+1] <= fits ? n_s[j] - trial : n_s[j];
				r_s[j+1] <= fits ? (r_s[j] >> 1) + BIT : (r_s[j] >> 1);
				d_s[j+1] <= d_s[j];
			end
		end
	end

	assign out_valid = v_s[ROOT_STEPS];
	assign root      = r_s[ROOT_STEPS][RW-2:0];
	assign side_out  = d_s[ROOT_STEPS];

endmodule
`default_nettype wire

/* rtl/q2e_atan2.sv */
`default_nettype none
module q2e_atan2
	import q2e_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_valid,
	input  wire sum_t    y_in,
	input  wire sum_t    x_in,
	output logic         out_valid,
	output logic [OW-1:0] angle
);

	logic v_s [0:STEPS];
	logic z0_s [0:STEPS];
	vec_t x_s [0:STEPS];
	vec_t y_s [0:STEPS];
	ang_t a_s [0:STEPS];
	ang_t rounded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// A vector in the left half plane is turned by a half turn first.
	always_ff @(posedge clk) begin
		if (en) begin
			z0_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -CW'(x_in);
				y_s[0] <= -CW'(y_in);
				a_s[0] <= HALF_TURN;
			end else begin
				x_s[0] <= CW'(x_in);
				y_s[0] <= CW'(y_in);
				a_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam ang_t T = atan_turn(i);
		vec_t xs, ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				z0_s[i+1] <= z0_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					a_s[i+1] <= a_s[i] + T;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					a_s[i+1] <= a_s[i] - T;
				end
			end
		end
	end

	assign rounded   = a_s[STEPS] + ROUND_HALF;
	assign out_valid = v_s[STEPS];
	assign angle     = z0_s[STEPS] ? '0 : rounded[AW-1:AW-OW];

endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_core.sv */
// Channel  Dir  Bits  Contents
// s_       in   64    quat_w, quat_x, quat_y, quat_z (Q2.14)
// m_       out  48    roll_angle, pitch_angle, yaw_angle (65536 per turn)
//
// One beat is taken every cycle while the pipeline is not held (see below).
// The pipeline runs through the 29-step pipelined square root for pitch and
// the 30-step pipelined vectoring units that follow it.
// arst_n clears all valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits at m_ and m_tready is low.
`default_nettype none
module quaternion_to_euler_core
	import q2e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // roll_angle, pitch_angle, yaw_angle
);

	localparam int SIDE_W = 5 * SW + 1;

	logic en;
	logic signed [QW-1:0] qw, qx, qy, qz;

	logic v_s1, v_s2, v_s3;
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	sum_t sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	sum_t sr_s3, cr_s3, sy_s3, cy_s3, py_s3;
	logic clamp_s3;
	logic [NW-1:0] sq_s3;
	logic signed [28:0] sp_n;
	logic signed [57:0] sp_sq;

	logic sq_valid;
	logic [RW-2:0] root;
	logic [SIDE_W-1:0] side_out;
	sum_t sr_r, cr_r, sy_r, cy_r, py_r;
	logic clamp_r;
	sum_t px;

	logic v_roll, v_pitch, v_yaw;
	logic [OW-1:0] roll, pitch, yaw;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign {qz, qy, qx, qw} = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sp_n  = sp_s2[28:0];
	assign sp_sq = sp_n * sp_n;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;

			sr_s2 <= (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
			cr_s2 <= ONE - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			sp_s2 <= (SW'(wy_s1) - SW'(zx_s1)) <<< 1;
			sy_s2 <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			cy_s2 <= ONE - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);

			// Out of range pitch becomes a straight up or down vector.
			sr_s3 <= sr_s2;
			cr_s3 <= cr_s2;
			sy_s3 <= sy_s2;
			cy_s3 <= cy_s2;
			sq_s3 <= sp_sq[NW-1:0];
			if (sp_s2 >= ONE) begin
				py_s3    <= ONE;
				clamp_s3 <= 1'b1;
			end else if (sp_s2 <= -ONE) begin
				py_s3    <= -ONE;
				clamp_s3 <= 1'b1;
			end else begin
				py_s3    <= sp_s2;
				clamp_s3 <= 1'b0;
			end
		end
	end

	q2e_isqrt #(
		.SIDE_W(SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.sq       (sq_s3),
		.side_in  ({sr_s3, cr_s3, sy_s3, cy_s3, py_s3, clamp_s3}),
		.out_valid(sq_valid),
		.root     (root),
		.side_out (side_out)
	);

	assign {sr_r, cr_r, sy_r, cy_r, py_r, clamp_r} = side_out;
	assign px = clamp_r ? '0 : SW'(root);

	q2e_atan2 u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_valid),
		.y_in(sr_r), .x_in(cr_r), .out_valid(v_roll), .angle(roll)
	);

	q2e_atan2 u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_valid),
		.y_in(py_r), .x_in(px), .out_valid(v_pitch), .angle(pitch)
	);

	q2e_atan2 u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_valid),
		.y_in(sy_r), .x_in(cy_r), .out_valid(v_yaw), .angle(yaw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_roll && v_pitch && v_yaw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {yaw, pitch, roll};
		end
	end

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384
			&& $signed(m_tdata[31:16]) >= -16'sd16384))
		else $error("pitch beyond a quarter turn");

	a_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without being taken");

	a_rise_moves: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("result appeared while the pipeline was held");

endmodule
`default_nettype wire

/* test/tb_quaternion_to_euler_core.sv */
`timescale 1ns / 1ps
module tb_quaternion_to_euler_core;
	import q2e_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;

	quaternion_to_euler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	logic [63:0] quat_pending[$];
	logic [47:0] angles_due[$];
	int errors = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	localparam logic [31:0] ATAN_TAB[30] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	function automatic logic [15:0] vector_angle(longint sy, longint sx);
		longint vx, vy, tx, ty;
		logic [31:0] acc;
		logic [31:0] rounded;
		acc = '0;
		vx = sx;
		vy = sy;
		if (vx == 0 && vy == 0)
			return 16'd0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < 30; i++) begin
			// Arithmetic right shift of a signed value is a floor shift.
			tx = vx >>> i;
			ty = vy >>> i;
			if (vy >= 0) begin
				vx = vx + ty;
				vy = vy - tx;
				acc = acc + ATAN_TAB[i];
			end else begin
				vx = vx - ty;
				vy = vy + tx;
				acc = acc - ATAN_TAB[i];
			end
		end
		rounded = acc + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [47:0] euler_of(logic [63:0] q);
		longint w, x, y, z, one, sr, cr, sp, sy, cy;
		logic [15:0] roll, pitch, yaw;
		longint unsigned c;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		one = 64'sd1 <<< 28;
		sr = 2 * (w * x + y * z);
		cr = one - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = one - 2 * (y * y + z * z);
		if (sp >= one)
			pitch = 16'd16384;
		else if (sp <= -one)
			pitch = 16'hC000;
		else begin
			c = int_sqrt((64'd1 << 56) - longint'(sp * sp));
			pitch = vector_angle(sp, longint'(c));
		end
		roll = vector_angle(sr, cr);
		yaw = vector_angle(sy, cy);
		return {yaw, pitch, roll};
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($signed($urandom_range(0, 24000)) - 12000);
		endcase
	endfunction

	// Roughly unit quaternion with random content.
	function automatic logic [63:0] rand_unit();
		real a, b, cc, d, n;
		a = real'($signed($urandom_range(0, 2000))) - 1000.0;
		b = real'($signed($urandom_range(0, 2000))) - 1000.0;
		cc = real'($signed($urandom_range(0, 2000))) - 1000.0;
		d = real'($signed($urandom_range(0, 2000))) - 1000.0;
		n = $sqrt(a * a + b * b + cc * cc + d * d) + 1.0;
		return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(cc / n * 16384.0)),
			16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				angles_due.push_back(euler_of(s_tdata));
				send_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0)
					send_gap = 0;
			end
			if ((!s_tvalid || s_tready) && !hold_off && send_gap == 0
					&& quat_pending.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= quat_pending.pop_front();
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
				if (send_gap > 0)
					send_gap--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (angles_due.size() == 0) begin
					$display("%0t: result with none due: got %h", $time, m_tdata);
					errors++;
				end else begin
					logic [47:0] want;
					want = angles_due.pop_front();
					if (want[15:0] !== m_tdata[15:0]) begin
						$display("%0t: roll expected %0d got %0d", $time,
							$signed(want[15:0]), $signed(m_tdata[15:0]));
						errors++;
					end
					if (want[31:16] !== m_tdata[31:16]) begin
						$display("%0t: pitch expected %0d got %0d", $time,
							$signed(want[31:16]), $signed(m_tdata[31:16]));
						errors++;
					end
					if (want[47:32] !== m_tdata[47:32]) begin
						$display("%0t: yaw expected %0d got %0d", $time,
							$signed(want[47:32]), $signed(m_tdata[47:32]));
						errors++;
					end
				end
				recv_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0)
					recv_gap = 0;
			end
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] edge_vals[6];
		edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
		// Identity, zero vector, extremes, gimbal lock both ways, half turns, a quarter turn of yaw.
		quat_pending.push_back({16'h0000, 16'h0000, 16'h0000, 16'h4000});
		quat_pending.push_back(64'h0);
		quat_pending.push_back({4{16'h8000}});
		quat_pending.push_back({4{16'h7FFF}});
		quat_pending.push_back({16'h0000, 16'h2D41, 16'h0000, 16'h2D41});
		quat_pending.push_back({16'h0000, 16'hD2BF, 16'h0000, 16'h2D41});
		quat_pending.push_back({16'h0000, 16'h0000, 16'h4000, 16'h0000});
		quat_pending.push_back({16'h4000, 16'h0000, 16'h0000, 16'h0000});
		quat_pending.push_back({16'h0000, 16'h4000, 16'h0000, 16'h0000});
		quat_pending.push_back({16'h2D41, 16'h0000, 16'h0000, 16'h2D41});
		for (int i = 0; i < 12; i++)
			quat_pending.push_back({edge_vals[$urandom_range(0, 5)],
				edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)],
				edge_vals[i % 6]});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (quat_pending.size() == 0 && s_tvalid == 1'b0);
		// Let the pipeline drain completely before the random part.
		hold_off = 1'b1;
		wait (angles_due.size() == 0);
		hold_off = 1'b0;
		for (int i = 0; i < 500; i++) begin
			if ($urandom_range(0, 9) < 6)
				quat_pending.push_back(rand_unit());
			else
				quat_pending.push_back({rand_comp(), rand_comp(), rand_comp(),
					rand_comp()});
		end
		wait (quat_pending.size() == 0 && s_tvalid == 1'b0);
		wait (angles_due.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
